// ===== rtl/core/tcx_pkg.sv =====
// ----------------------------------------------------------------------------
// tcx_pkg
// Shared types and codes for the toy CPU execute unit.
// ----------------------------------------------------------------------------
package tcx_pkg;

	// request opcodes
	localparam logic [4:0] OP_ADD  = 5'd0;
	localparam logic [4:0] OP_SUB  = 5'd1;
	localparam logic [4:0] OP_MUL  = 5'd2;
	localparam logic [4:0] OP_DIV  = 5'd3;
	localparam logic [4:0] OP_AND  = 5'd4;
	localparam logic [4:0] OP_OR   = 5'd5;
	localparam logic [4:0] OP_XOR  = 5'd6;
	localparam logic [4:0] OP_NOT  = 5'd7;
	localparam logic [4:0] OP_SHL  = 5'd8;
	localparam logic [4:0] OP_SHR  = 5'd9;
	localparam logic [4:0] OP_CMP  = 5'd10;
	localparam logic [4:0] OP_INC  = 5'd11;
	localparam logic [4:0] OP_DEC  = 5'd12;
	localparam logic [4:0] OP_NEG  = 5'd13;
	localparam logic [4:0] OP_MOVE = 5'd14;
	localparam logic [4:0] OP_STB  = 5'd15;
	localparam logic [4:0] OP_STW  = 5'd16;
	localparam logic [4:0] OP_LDB  = 5'd17;
	localparam logic [4:0] OP_PUSH = 5'd18;
	localparam logic [4:0] OP_POP  = 5'd19;
	localparam logic [4:0] OP_JMP  = 5'd20;
	localparam logic [4:0] OP_JE   = 5'd21;
	localparam logic [4:0] OP_JNE  = 5'd22;
	localparam logic [4:0] OP_JL   = 5'd23;
	localparam logic [4:0] OP_JG   = 5'd24;
	localparam logic [4:0] OP_QUIT = 5'd25;
	localparam logic [4:0] OP_NOP  = 5'd26;

	// source operand kinds
	localparam logic [2:0] AK_REG   = 3'd0;
	localparam logic [2:0] AK_IMM   = 3'd1;
	localparam logic [2:0] AK_ABS   = 3'd2;
	localparam logic [2:0] AK_VIA8  = 3'd3;
	localparam logic [2:0] AK_VIA16 = 3'd4;

	// destination operand kinds
	localparam logic [1:0] BK_REG   = 2'd0;
	localparam logic [1:0] BK_ABS   = 2'd1;
	localparam logic [1:0] BK_VIA8  = 2'd2;
	localparam logic [1:0] BK_VIA16 = 2'd3;

	// status codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_DIVZ   = 3'd1;
	localparam logic [2:0] ST_OOB    = 3'd2;
	localparam logic [2:0] ST_OVF    = 3'd3;
	localparam logic [2:0] ST_UNF    = 3'd4;
	localparam logic [2:0] ST_REGION = 3'd5;
	localparam logic [2:0] ST_BAD    = 3'd6;
	localparam logic [2:0] ST_HALT   = 3'd7;

	// configuration register indexes
	localparam logic CFG_SMALL_RAM = 1'b0;
	localparam logic CFG_STACK     = 1'b1;

	// address math width: 16-bit address plus carry
	localparam int ADDR_W = 17;

	typedef struct packed {
		logic [4:0]  req_type;
		logic        wide;
		logic        signed_mode;
		logic [2:0]  a_kind;
		logic [4:0]  a_reg;
		logic [15:0] a_value;
		logic [1:0]  b_kind;
		logic [4:0]  b_reg;
		logic [15:0] b_value;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        branch_taken;
		logic        zero_flag;
		logic        sign_flag;
		logic [15:0] result_value;
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_RA,
		S_RB,
		S_RDA0,
		S_RDA1,
		S_RDB0,
		S_RDB1,
		S_EXEC,
		S_DIV,
		S_WB,
		S_WRHI,
		S_DONE
	} state_t;

endpackage

// ===== rtl/core/toy_cpu_execute_unit.sv =====
// ----------------------------------------------------------------------------
// toy_cpu_execute_unit
// Executes one decoded instruction per request against register files,
// byte memory, stack pointer and flags.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake              Payload
// req       in   req_valid / req_stall  tcx_pkg::req_t
// rsp       out  rsp_valid / rsp_stall  tcx_pkg::rsp_t
// cfg       in   cfg_we                 cfg_addr, cfg_wdata
//
// Flow: one request at a time; DIV adds the S_DIV pass and a word
//   memory write adds S_WRHI for the high byte; the single memory port
//   sets this (operand bytes are read and written one at a time).
// Reset: a clearing pass over all MEM_BYTES addresses zeroes memory and
//   both register files; req_stall stays high meanwhile.
// Stalls: the response register lets a new request be accepted while the
//   previous response waits; the next one waits in S_DONE until taken.
//
module toy_cpu_execute_unit #(
	parameter int MEM_BYTES = 65536,
	parameter int REG_COUNT = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  tcx_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output tcx_pkg::rsp_t  rsp,
	input  logic           cfg_we,
	input  logic           cfg_addr,
	input  logic [10:0]    cfg_wdata
);
	import tcx_pkg::*;

	localparam int AW = $clog2(MEM_BYTES);
	localparam int RW = $clog2(REG_COUNT);

	// ---------------- storage ----------------
	logic [7:0]  mem [MEM_BYTES];
	logic [7:0]  brf [REG_COUNT];
	logic [15:0] wrf [REG_COUNT];

	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, mem_rdata_q;
	logic          brf_we, wrf_we;
	logic [RW-1:0] rf_waddr, rf_raddr;
	logic [7:0]    brf_wdata, brf_rdata_q;
	logic [15:0]   wrf_wdata, wrf_rdata_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (brf_we) begin
			brf[rf_waddr] <= brf_wdata;
		end
		if (wrf_we) begin
			wrf[rf_waddr] <= wrf_wdata;
		end
		brf_rdata_q <= brf[rf_raddr];
		wrf_rdata_q <= wrf[rf_raddr];
	end

	// ---------------- control state ----------------
	state_t state_q, state_d;
	logic [AW-1:0] clr_q;
	logic [3:0]    div_cnt_q;

	logic [8:0]        small_q;
	logic [10:0]       stack_q;
	logic [ADDR_W-1:0] ram_off_q, stk_base_q, sp_q;
	logic              zf_q, sf_q;

	logic rsp_valid_q;
	rsp_t rsp_q;

	// captured request and operands
	req_t        req_q;
	logic [7:0]  ba_q, bb_q, alo_q, ahi_q, blo_q;
	logic [15:0] wa_q, wb_q;

	// execute results
	logic [2:0]        st_q;
	logic              br_q;
	logic [15:0]       res_q;
	logic              do_reg_q, rwide_q, do_mem_q, mword_q;
	logic [ADDR_W-1:0] maddr_q;

	// divider
	logic [15:0] dvd_q, rem_q, dvs_q;
	logic        qneg_q;

	// ---------------- layout on config write ----------------
	logic [8:0]        cfg_small, lay_s;
	logic [10:0]       cfg_stack, lay_k0;
	logic [ADDR_W-1:0] lay_ram_off, lay_k, lay_base;

	always_comb begin
		cfg_small = (cfg_addr == CFG_SMALL_RAM) ? cfg_wdata[8:0] : small_q;
		cfg_stack = (cfg_addr == CFG_STACK) ? cfg_wdata : stack_q;
		lay_s = cfg_small;
		if (cfg_small == 9'd0) begin
			lay_s = 9'd1;
		end else if (cfg_small > 9'd256) begin
			lay_s = 9'd256;
		end
		lay_ram_off = ADDR_W'(MEM_BYTES) - ADDR_W'(lay_s);
		lay_k0 = (cfg_stack > 11'd1024) ? 11'd1024 : cfg_stack;
		lay_k = (ADDR_W'(lay_k0) > lay_ram_off) ? lay_ram_off : ADDR_W'(lay_k0);
		lay_base = lay_ram_off - lay_k;
	end

	// ---------------- operand plan ----------------
	logic [4:0]        t;
	logic              w, ww, uw, a_rw, b_rw;
	logic              is_bin, is_un, is_st;
	logic              a_rg_ok, b_rg_ok, sa_bad, sb_bad;
	logic              a_memsrc, b_is_mem, a_oob, b_oob;
	logic [ADDR_W-1:0] a_addr, b_addr, push_addr;
	logic [15:0]       av, bv, bhi;
	logic [ADDR_W-1:0] n_step;

	always_comb begin
		t = req_q.req_type;
		w = req_q.wide;
		is_bin = t inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_XOR,
			OP_SHL, OP_SHR};
		is_un = t inside {OP_NOT, OP_INC, OP_DEC, OP_NEG};
		is_st = t inside {OP_STB, OP_STW};
		ww = (t == OP_STW);
		uw = (t == OP_NOT || req_q.b_kind == BK_REG) ? w : 1'b0;
		a_rw = is_st ? ww : ((t == OP_LDB) ? 1'b0 : w);
		b_rw = is_un ? uw : (is_st ? ww : w);

		a_rg_ok = 32'(req_q.a_reg) < REG_COUNT;
		b_rg_ok = 32'(req_q.b_reg) < REG_COUNT;
		sa_bad = (req_q.a_kind > AK_VIA16) ||
			((req_q.a_kind inside {AK_REG, AK_VIA8, AK_VIA16}) && !a_rg_ok);
		sb_bad = (req_q.b_kind != BK_ABS) && !b_rg_ok;

		a_memsrc = (req_q.a_kind inside {AK_ABS, AK_VIA8, AK_VIA16}) ||
			t == OP_LDB || t == OP_POP;
		b_is_mem = (req_q.b_kind != BK_REG);

		if (t == OP_POP) begin
			a_addr = sp_q;
		end else begin
			case (req_q.a_kind)
				AK_VIA8:  a_addr = ADDR_W'(ba_q);
				AK_VIA16: a_addr = ADDR_W'(wa_q);
				default:  a_addr = ADDR_W'(req_q.a_value);
			endcase
		end
		case (req_q.b_kind)
			BK_VIA8:  b_addr = ADDR_W'(bb_q);
			BK_VIA16: b_addr = ADDR_W'(wb_q);
			default:  b_addr = ADDR_W'(req_q.b_value);
		endcase

		a_oob = a_rw ? (a_addr + 1'b1 >= ADDR_W'(MEM_BYTES))
			: (a_addr >= ADDR_W'(MEM_BYTES));
		b_oob = b_rw ? (b_addr + 1'b1 >= ADDR_W'(MEM_BYTES))
			: (b_addr >= ADDR_W'(MEM_BYTES));

		// high byte of b arrives straight from the memory in S_EXEC
		bhi = {8'd0, mem_rdata_q};
		if (a_memsrc) begin
			av = {a_rw ? ahi_q : 8'd0, alo_q};
		end else if (req_q.a_kind == AK_IMM) begin
			av = a_rw ? req_q.a_value : {8'd0, req_q.a_value[7:0]};
		end else begin
			av = a_rw ? wa_q : {8'd0, ba_q};
		end
		if (b_is_mem) begin
			bv = {b_rw ? bhi[7:0] : 8'd0, blo_q};
		end else begin
			bv = b_rw ? wb_q : {8'd0, bb_q};
		end

		n_step = w ? ADDR_W'(2) : ADDR_W'(1);
		push_addr = sp_q - n_step;
	end

	// ---------------- execute ----------------
	logic [2:0]        ex_st;
	logic              ex_br, ex_reg, ex_mem, ex_mword, ex_flags, ex_div;
	logic [ADDR_W-1:0] ex_maddr, ex_sp;
	logic [15:0]       ex_res, mask, umask;
	logic [31:0]       prod;
	logic [15:0]       ax, bx, amag, bmag;
	logic              aneg, bneg;

	always_comb begin
		mask = w ? 16'hFFFF : 16'h00FF;
		umask = uw ? 16'hFFFF : 16'h00FF;
		prod = 32'(bv) * 32'(av);
		ax = (req_q.signed_mode && !w) ? {{8{av[7]}}, av[7:0]} : av;
		bx = (req_q.signed_mode && !w) ? {{8{bv[7]}}, bv[7:0]} : bv;
		aneg = req_q.signed_mode && ax[15];
		bneg = req_q.signed_mode && bx[15];
		amag = aneg ? (~ax + 16'd1) : ax;
		bmag = bneg ? (~bx + 16'd1) : bx;

		ex_st = ST_OK;
		ex_br = 1'b0;
		ex_res = 16'd0;
		ex_reg = 1'b0;
		ex_mem = 1'b0;
		ex_mword = 1'b0;
		ex_maddr = b_addr;
		ex_flags = 1'b0;
		ex_div = 1'b0;
		ex_sp = sp_q;

		if (is_bin) begin
			if (sa_bad) ex_st = ST_BAD;
			else if (a_oob && a_memsrc) ex_st = ST_OOB;
			else if (t == OP_DIV && av == 16'd0) ex_st = ST_DIVZ;
			else if (sb_bad) ex_st = ST_BAD;
			else if (b_oob && b_is_mem) ex_st = ST_OOB;
			case (t)
				OP_ADD:  ex_res = bv + av;
				OP_SUB:  ex_res = bv - av;
				OP_MUL:  ex_res = prod[15:0];
				OP_AND:  ex_res = bv & av;
				OP_OR:   ex_res = bv | av;
				OP_XOR:  ex_res = bv ^ av;
				OP_SHL:  ex_res = (av >= (w ? 16'd16 : 16'd8)) ? 16'd0 : (bv << av[3:0]);
				OP_SHR:  ex_res = (av >= (w ? 16'd16 : 16'd8)) ? 16'd0 : (bv >> av[3:0]);
				default: ex_res = 16'd0;
			endcase
			ex_res = ex_res & mask;
			ex_div = (t == OP_DIV);
			ex_reg = !b_is_mem;
			ex_mem = b_is_mem;
			ex_mword = w;
		end else if (is_un) begin
			if (sb_bad) ex_st = ST_BAD;
			else if (b_oob && b_is_mem) ex_st = ST_OOB;
			case (t)
				OP_NOT:  ex_res = ~bv;
				OP_INC:  ex_res = bv + 16'd1;
				OP_DEC:  ex_res = bv - 16'd1;
				default: ex_res = 16'd0 - bv;
			endcase
			ex_res = ex_res & umask;
			ex_reg = !b_is_mem;
			ex_mem = b_is_mem;
			ex_mword = uw;
		end else begin
			case (t)
				OP_CMP: begin
					if (sa_bad) ex_st = ST_BAD;
					else if (a_oob && a_memsrc) ex_st = ST_OOB;
					else if (sb_bad) ex_st = ST_BAD;
					else if (b_oob && b_is_mem) ex_st = ST_OOB;
					ex_flags = 1'b1;
				end
				OP_MOVE: begin
					if (sa_bad) ex_st = ST_BAD;
					else if (sb_bad || b_is_mem) ex_st = ST_BAD;
					else if (a_oob && a_memsrc) ex_st = ST_OOB;
					ex_res = av;
					ex_reg = 1'b1;
				end
				OP_STB, OP_STW: begin
					if (sa_bad) ex_st = ST_BAD;
					else if (sb_bad || !b_is_mem) ex_st = ST_BAD;
					else if (a_oob && a_memsrc) ex_st = ST_OOB;
					else if (!ww && !w && b_addr < ram_off_q) ex_st = ST_REGION;
					else if (b_oob) ex_st = ST_OOB;
					ex_res = av;
					ex_mem = 1'b1;
					ex_mword = ww;
				end
				OP_LDB: begin
					if (sa_bad || req_q.a_kind == AK_REG) ex_st = ST_BAD;
					else if (sb_bad || b_is_mem) ex_st = ST_BAD;
					else if (!w && a_addr < ram_off_q) ex_st = ST_REGION;
					else if (a_oob) ex_st = ST_OOB;
					ex_res = av;
					ex_reg = 1'b1;
				end
				OP_PUSH: begin
					if (sa_bad) ex_st = ST_BAD;
					else if (a_oob && a_memsrc) ex_st = ST_OOB;
					else if (sp_q < stk_base_q + n_step) ex_st = ST_OVF;
					ex_res = av;
					ex_mem = 1'b1;
					ex_mword = w;
					ex_maddr = push_addr;
					ex_sp = push_addr;
				end
				OP_POP: begin
					if (sb_bad || b_is_mem) ex_st = ST_BAD;
					else if (sp_q + n_step - 1'b1 >= ram_off_q) ex_st = ST_UNF;
					ex_res = av;
					ex_reg = 1'b1;
					ex_sp = sp_q + n_step;
				end
				OP_JMP:  ex_br = 1'b1;
				OP_JE:   ex_br = zf_q;
				OP_JNE:  ex_br = !zf_q;
				OP_JL:   ex_br = sf_q;
				OP_JG:   ex_br = !sf_q && !zf_q;
				OP_QUIT: ex_st = ST_HALT;
				OP_NOP:  ex_st = ST_OK;
				default: ex_st = ST_BAD;
			endcase
		end

		if (ex_st != ST_OK) begin
			ex_res = 16'd0;
			ex_br = 1'b0;
			ex_reg = 1'b0;
			ex_mem = 1'b0;
			ex_flags = 1'b0;
			ex_div = 1'b0;
			ex_sp = sp_q;
		end
	end

	// one restoring-divide step on magnitudes
	logic [16:0] div_trial, div_diff;
	logic [15:0] div_quo, div_final;

	always_comb begin
		div_trial = {rem_q, dvd_q[15]};
		div_diff = div_trial - {1'b0, dvs_q};
		div_quo = {dvd_q[14:0], !div_diff[16]};
		div_final = qneg_q ? (16'd0 - div_quo) : div_quo;
		div_final = div_final & (req_q.wide ? 16'hFFFF : 16'h00FF);
	end

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (clr_q == AW'(MEM_BYTES - 1)) state_d = S_IDLE;
			S_IDLE:  if (req_valid) state_d = S_RA;
			S_RA:    state_d = S_RB;
			S_RB:    state_d = S_RDA0;
			S_RDA0:  state_d = S_RDA1;
			S_RDA1:  state_d = S_RDB0;
			S_RDB0:  state_d = S_RDB1;
			S_RDB1:  state_d = S_EXEC;
			S_EXEC:  state_d = ex_div ? S_DIV : S_WB;
			S_DIV:   if (div_cnt_q == 4'd15) state_d = S_WB;
			S_WB:    state_d = (do_mem_q && mword_q) ? S_WRHI : S_DONE;
			S_WRHI:  state_d = S_DONE;
			S_DONE:  if (!rsp_valid_q || !rsp_stall) state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	// ---------------- storage port control ----------------
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = maddr_q[AW-1:0];
		mem_wdata = res_q[7:0];
		mem_raddr = a_addr[AW-1:0];
		brf_we = 1'b0;
		wrf_we = 1'b0;
		rf_waddr = req_q.b_reg[RW-1:0];
		brf_wdata = res_q[7:0];
		wrf_wdata = res_q;
		rf_raddr = req.a_reg[RW-1:0];
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = 8'd0;
				rf_waddr = clr_q[RW-1:0];
				brf_we = 32'(clr_q) < REG_COUNT;
				wrf_we = 32'(clr_q) < REG_COUNT;
				brf_wdata = 8'd0;
				wrf_wdata = 16'd0;
			end
			S_RA:   rf_raddr = req_q.b_reg[RW-1:0];
			S_RDA0: mem_raddr = a_addr[AW-1:0];
			S_RDA1: mem_raddr = AW'(a_addr + 1'b1);
			S_RDB0: mem_raddr = b_addr[AW-1:0];
			S_RDB1: mem_raddr = AW'(b_addr + 1'b1);
			S_WB: begin
				mem_we = do_mem_q;
				brf_we = do_reg_q && !rwide_q;
				wrf_we = do_reg_q && rwide_q;
			end
			S_WRHI: begin
				mem_we = 1'b1;
				mem_waddr = AW'(maddr_q + 1'b1);
				mem_wdata = res_q[15:8];
			end
			default: ;
		endcase
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			div_cnt_q <= '0;
			small_q <= 9'd256;
			stack_q <= 11'd1024;
			ram_off_q <= ADDR_W'(MEM_BYTES - 256);
			stk_base_q <= ADDR_W'(MEM_BYTES - 1280);
			sp_q <= ADDR_W'(MEM_BYTES - 256);
			zf_q <= 1'b0;
			sf_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == S_DIV) begin
				div_cnt_q <= div_cnt_q + 4'd1;
			end else begin
				div_cnt_q <= '0;
			end
			if (cfg_we) begin
				small_q <= cfg_small;
				stack_q <= cfg_stack;
				ram_off_q <= lay_ram_off;
				stk_base_q <= lay_base;
				sp_q <= lay_ram_off;
			end else if (state_q == S_EXEC) begin
				sp_q <= ex_sp;
			end
			if (state_q == S_EXEC && ex_flags) begin
				zf_q <= (bv == av);
				sf_q <= (bv < av);
			end
			if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == S_RA) begin
			ba_q <= brf_rdata_q;
			wa_q <= wrf_rdata_q;
		end
		if (state_q == S_RB) begin
			bb_q <= brf_rdata_q;
			wb_q <= wrf_rdata_q;
		end
		if (state_q == S_RDA1) alo_q <= mem_rdata_q;
		if (state_q == S_RDB0) ahi_q <= mem_rdata_q;
		if (state_q == S_RDB1) blo_q <= mem_rdata_q;
		if (state_q == S_EXEC) begin
			st_q <= ex_st;
			br_q <= ex_br;
			res_q <= ex_res;
			do_reg_q <= ex_reg;
			rwide_q <= (t == OP_LDB) ? 1'b0 : (is_un ? uw : w);
			do_mem_q <= ex_mem;
			mword_q <= ex_mword;
			maddr_q <= ex_maddr;
			dvd_q <= amag;
			dvd_q <= bmag;
			dvs_q <= amag;
			rem_q <= 16'd0;
			qneg_q <= aneg ^ bneg;
		end
		if (state_q == S_DIV) begin
			rem_q <= div_diff[16] ? div_trial[15:0] : div_diff[15:0];
			dvd_q <= div_quo;
			if (div_cnt_q == 4'd15) begin
				res_q <= div_final;
			end
		end
		if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q.status <= st_q;
			rsp_q.branch_taken <= br_q;
			rsp_q.zero_flag <= zf_q;
			rsp_q.sign_flag <= sf_q;
			rsp_q.result_value <= res_q;
		end
	end

	// ---------------- assertions ----------------
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("response raised outside S_DONE");

	a_sp_in_stack: assert property (@(posedge clk) disable iff (!arst_n)
		(sp_q >= stk_base_q) && (sp_q <= ram_off_q))
		else $error("stack pointer left the stack region");

	a_write_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_CLEAR || st_q == ST_OK))
		else $error("memory written by a faulting request");

endmodule

// ===== tb/tb_toy_cpu_execute_unit.sv =====
// ----------------------------------------------------------------------------
// tb_toy_cpu_execute_unit
// Self-checking bench for the execute unit. It runs directed and random
// instructions under several memory layouts and checks every response
// against an in-bench model of registers, memory, stack and flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_toy_cpu_execute_unit;
	import tcx_pkg::*;

	localparam int MEM_SIZE   = 65536;
	localparam int LIMIT      = 500000;
	localparam int DRAIN      = 40;
	localparam int RAND_ITEMS = 140;    // per layout phase, five phases

	logic  clk, arst_n;
	logic  req_valid, req_stall, rsp_valid, rsp_stall;
	req_t  req;
	rsp_t  rsp;
	logic  cfg_we, cfg_addr;
	logic [10:0] cfg_wdata;

	toy_cpu_execute_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	// ---- shadow machine state ----
	logic [7:0]  shadow_b [32];
	logic [15:0] shadow_w [32];
	logic [7:0]  shadow_mem [MEM_SIZE];
	int          sp, ram_off, stk_base, stk_top;
	int          ram_cfg, stk_cfg;
	bit          zf, sf;

	rsp_t        pending_rsp[$];
	int          cycles, errors, mismatches, n_sent, n_checked;
	int          n_status[8];
	bit          no_gaps, hold_off;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d responses pending", cycles, pending_rsp.size());
			$display("tb_toy_cpu_execute_unit: errors");
			$finish;
		end
	end

	// Recompute the memory map; sp goes back to the top of the stack.
	function automatic void set_layout();
		int s, k;
		s = ram_cfg;
		k = stk_cfg;
		if (s == 0) s = 1;
		if (s > 256) s = 256;
		ram_off = MEM_SIZE - s;
		if (k > 1024) k = 1024;
		if (k > ram_off) k = ram_off;
		stk_base = ram_off - k;
		stk_top  = ram_off;
		sp       = stk_top;
	endfunction

	// Operand decode. kind in source coding: 0 reg, 1 imm, 2 abs, 3 via r8, 4 via r16.
	// Result k: 0 register, 1 immediate, 2 memory.
	function automatic logic [2:0] decode_opnd(int kind, int ri, int val,
	                                           output int k, output int v);
		k = 0;
		v = val;
		case (kind)
			0: k = 0;
			1: k = 1;
			2: k = 2;
			3: begin k = 2; v = shadow_b[ri]; end
			4: begin k = 2; v = shadow_w[ri]; end
			default: return ST_BAD;
		endcase
		return ST_OK;
	endfunction

	function automatic logic [2:0] bounds(int addr, bit w);
		if (w) return (addr + 1 < MEM_SIZE) ? ST_OK : ST_OOB;
		return (addr < MEM_SIZE) ? ST_OK : ST_OOB;
	endfunction

	function automatic logic [2:0] read_opnd(int k, int ri, int v, bit w, output int d);
		d = 0;
		if (k == 0) begin
			d = w ? shadow_w[ri] : shadow_b[ri];
			return ST_OK;
		end
		if (k == 1) begin
			d = v & (w ? 'hFFFF : 'hFF);
			return ST_OK;
		end
		if (bounds(v, w) != ST_OK) return ST_OOB;
		d = shadow_mem[v];
		if (w) d = d | (shadow_mem[v + 1] << 8);
		return ST_OK;
	endfunction

	function automatic logic [2:0] write_opnd(int k, int ri, int v, bit w, int d);
		if (k == 1) return ST_BAD;
		if (k == 0) begin
			if (w) shadow_w[ri] = d[15:0];
			else   shadow_b[ri] = d[7:0];
			return ST_OK;
		end
		if (bounds(v, w) != ST_OK) return ST_OOB;
		shadow_mem[v] = d[7:0];
		if (w) shadow_mem[v + 1] = d[15:8];
		return ST_OK;
	endfunction

	function automatic int sext(int v, bit w);
		if (w) return v[15] ? v - 65536 : v;
		return v[7] ? v - 256 : v;
	endfunction

	// Executes one instruction on the shadow state; returns status.
	function automatic logic [2:0] run_instr(req_t q, output int res, output bit br);
		int ak, av, bk, bv, aval, bval, r, mask, wbits, n, uw;
		logic [2:0] sa, sb, s;
		bit w;
		w     = q.wide;
		mask  = w ? 'hFFFF : 'hFF;
		wbits = w ? 16 : 8;
		res   = 0;
		br    = 0;
		aval  = 0;
		bval  = 0;
		r     = 0;
		sa = decode_opnd(q.a_kind, q.a_reg, q.a_value, ak, av);
		sb = decode_opnd(q.b_kind == BK_REG ? 0 : q.b_kind + 1, q.b_reg, q.b_value, bk, bv);
		case (q.req_type)
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR: begin
				if (sa != ST_OK) return sa;
				s = read_opnd(ak, q.a_reg, av, w, aval);
				if (s != ST_OK) return s;
				if (q.req_type == OP_DIV && aval == 0) return ST_DIVZ;
				if (sb != ST_OK) return sb;
				s = read_opnd(bk, q.b_reg, bv, w, bval);
				if (s != ST_OK) return s;
				case (q.req_type)
					OP_ADD: r = bval + aval;
					OP_SUB: r = bval - aval;
					OP_MUL: r = bval * aval;
					OP_DIV: r = q.signed_mode ? sext(bval, w) / sext(aval, w) : bval / aval;
					OP_AND: r = bval & aval;
					OP_OR:  r = bval | aval;
					OP_XOR: r = bval ^ aval;
					OP_SHL: r = (aval >= wbits) ? 0 : bval << aval;
					default: r = (aval >= wbits) ? 0 : bval >> aval;
				endcase
				r = r & mask;
				s = write_opnd(bk, q.b_reg, bv, w, r);
				if (s != ST_OK) return s;
				res = r;
				return ST_OK;
			end
			OP_NOT, OP_INC, OP_DEC, OP_NEG: begin
				// memory operands are always byte wide, except for NOT
				uw = (q.req_type == OP_NOT || bk == 0) ? w : 0;
				if (sb != ST_OK) return sb;
				s = read_opnd(bk, q.b_reg, bv, uw, bval);
				if (s != ST_OK) return s;
				case (q.req_type)
					OP_NOT: r = ~bval;
					OP_INC: r = bval + 1;
					OP_DEC: r = bval - 1;
					default: r = -bval;
				endcase
				r = r & (uw ? 'hFFFF : 'hFF);
				s = write_opnd(bk, q.b_reg, bv, uw, r);
				if (s != ST_OK) return s;
				res = r;
				return ST_OK;
			end
			OP_CMP: begin
				if (sa != ST_OK) return sa;
				s = read_opnd(ak, q.a_reg, av, w, aval);
				if (s != ST_OK) return s;
				if (sb != ST_OK) return sb;
				s = read_opnd(bk, q.b_reg, bv, w, bval);
				if (s != ST_OK) return s;
				zf = (bval == aval);
				sf = (bval < aval);
				return ST_OK;
			end
			OP_MOVE: begin
				if (sa != ST_OK) return sa;
				if (sb != ST_OK || bk != 0) return ST_BAD;
				s = read_opnd(ak, q.a_reg, av, w, aval);
				if (s != ST_OK) return s;
				void'(write_opnd(bk, q.b_reg, bv, w, aval));
				res = aval;
				return ST_OK;
			end
			OP_STB, OP_STW: begin
				if (sa != ST_OK) return sa;
				if (sb != ST_OK || bk != 2) return ST_BAD;
				s = read_opnd(ak, q.a_reg, av, q.req_type == OP_STW, aval);
				if (s != ST_OK) return s;
				if (q.req_type == OP_STB && !w && bv < ram_off) return ST_REGION;
				s = write_opnd(bk, q.b_reg, bv, q.req_type == OP_STW, aval);
				if (s != ST_OK) return s;
				res = aval;
				return ST_OK;
			end
			OP_LDB: begin
				// an immediate source is taken as the address
				if (sa != ST_OK || ak == 0) return ST_BAD;
				if (sb != ST_OK || bk != 0) return ST_BAD;
				if (!w && av < ram_off) return ST_REGION;
				s = read_opnd(2, 0, av, 0, aval);
				if (s != ST_OK) return s;
				void'(write_opnd(bk, q.b_reg, bv, 0, aval));
				res = aval;
				return ST_OK;
			end
			OP_PUSH: begin
				n = w ? 2 : 1;
				if (sa != ST_OK) return sa;
				s = read_opnd(ak, q.a_reg, av, w, aval);
				if (s != ST_OK) return s;
				if (sp < stk_base + n) return ST_OVF;
				s = write_opnd(2, 0, sp - n, w, aval);
				if (s != ST_OK) return s;
				sp  = sp - n;
				res = aval;
				return ST_OK;
			end
			OP_POP: begin
				n = w ? 2 : 1;
				if (sb != ST_OK || bk != 0) return ST_BAD;
				if (sp + n - 1 >= stk_top) return ST_UNF;
				s = read_opnd(2, 0, sp, w, aval);
				if (s != ST_OK) return s;
				void'(write_opnd(bk, q.b_reg, bv, w, aval));
				sp  = sp + n;
				res = aval;
				return ST_OK;
			end
			OP_JMP: begin br = 1; return ST_OK; end
			OP_JE:  begin br = zf; return ST_OK; end
			OP_JNE: begin br = !zf; return ST_OK; end
			OP_JL:  begin br = sf; return ST_OK; end
			OP_JG:  begin br = !sf && !zf; return ST_OK; end
			OP_QUIT: return ST_HALT;
			OP_NOP:  return ST_OK;
			default: return ST_BAD;
		endcase
	endfunction

	function automatic rsp_t predict_rsp(req_t q);
		rsp_t e;
		int res;
		bit br;
		e.status = run_instr(q, res, br);
		if (e.status != ST_OK) begin
			res = 0;
			br  = 0;
		end
		e.branch_taken = br;
		e.zero_flag    = zf;
		e.sign_flag    = sf;
		e.result_value = res[15:0];
		return e;
	endfunction

	function automatic req_t mk(logic [4:0] t, bit w, bit sg, logic [2:0] ak, int ar,
	                            int av, logic [1:0] bk, int brg, int bv);
		req_t q;
		q.req_type    = t;
		q.wide        = w;
		q.signed_mode = sg;
		q.a_kind      = ak;
		q.a_reg       = ar[4:0];
		q.a_value     = av[15:0];
		q.b_kind      = bk;
		q.b_reg       = brg[4:0];
		q.b_value     = bv[15:0];
		return q;
	endfunction

	function automatic int gap_draw();
		return no_gaps ? 0 : $urandom_range(0, 4);
	endfunction

	// Addresses clustered where the interesting boundaries are.
	function automatic int pick_addr();
		case ($urandom_range(0, 6))
			0: return $urandom_range(0, 63);
			1: return 'hFF00 + $urandom_range(0, 255);
			2: return ram_off - 4 + $urandom_range(0, 7) > 'hFFFF ? 'hFFFF
			          : ram_off - 4 + $urandom_range(0, 7);
			3: return (sp > 4 ? sp - 4 : 0) + $urandom_range(0, 7);
			4: return 'hFFFE + $urandom_range(0, 1);
			default: return $urandom_range(0, 'hFFFF);
		endcase
	endfunction

	function automatic req_t rand_req();
		req_t q;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 10) begin
			// noise: every field fully random, including illegal codes
			q = req_t'({$urandom, $urandom});
		end else begin
			q = mk($urandom_range(0, 26), $urandom_range(0, 1), $urandom_range(0, 1),
			       $urandom_range(0, 4), $urandom_range(0, 31), 0,
			       $urandom_range(0, 3), $urandom_range(0, 31), pick_addr());
			if (sel < 40) q.b_kind = BK_REG;
			if (q.a_kind == AK_IMM)
				q.a_value = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : $urandom;
			else
				q.a_value = pick_addr();
			// bias toward stack traffic and compare/branch pairs
			if (sel >= 80 && sel < 88) q.req_type = $urandom_range(0, 1) ? OP_PUSH : OP_POP;
			if (sel >= 88) q.req_type = $urandom_range(0, 1) ? OP_CMP
			                            : OP_JMP + $urandom_range(0, 4);
		end
		return q;
	endfunction

	// ---- request side ----
	task automatic send_req(req_t q);
		int g;
		g = gap_draw();
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		req       <= q;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		pending_rsp.push_back(predict_rsp(q));
		n_sent++;
		@(negedge clk);
	endtask

	// Waits until the unit is idle, then writes both layout registers.
	task automatic set_map(int ram_val, int stk_val);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= CFG_SMALL_RAM;
		cfg_wdata <= ram_val[10:0];
		@(negedge clk);
		cfg_addr  <= CFG_STACK;
		cfg_wdata <= stk_val[10:0];
		@(negedge clk);
		cfg_we    <= 1'b0;
		ram_cfg = ram_val;
		stk_cfg = stk_val;
		set_layout();
	endtask

	// ---- response side ----
	initial begin
		int g;
		rsp_t e;
		rsp_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				// long hold-off: the unit fills and must stall its input
				hold_off = 0;
				rsp_stall <= 1'b1;
				repeat (300) @(negedge clk);
			end
			g = gap_draw();
			if (g > 0) begin
				rsp_stall <= 1'b1;
				repeat (g) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			if (pending_rsp.size() == 0) begin
				errors++;
				$display("unexpected response %p at cycle %0d", rsp, cycles);
			end else begin
				e = pending_rsp.pop_front();
				n_checked++;
				n_status[e.status]++;
				if (rsp.status !== e.status || rsp.branch_taken !== e.branch_taken ||
				    rsp.zero_flag !== e.zero_flag || rsp.sign_flag !== e.sign_flag ||
				    rsp.result_value !== e.result_value) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch #%0d cycle %0d: exp %p got %p",
						         n_checked, cycles, e, rsp);
				end
			end
		end
	end

	// ---- directed table ----
	typedef struct {
		req_t q;
		bit   typed;    // expected response written out in the row
		rsp_t e;
	} row_t;

	row_t table_rows[$];

	function automatic void add_row(req_t q, bit typed = 0, logic [2:0] st = ST_OK,
	                                int res = 0);
		row_t rw;
		rw.q = q;
		rw.typed = typed;
		rw.e = '{status: st, branch_taken: 1'b0, zero_flag: 1'b0, sign_flag: 1'b0,
		         result_value: res[15:0]};
		table_rows.push_back(rw);
	endfunction

	initial begin
		req_t q;
		rsp_t got;
		int   phase_ram[5], phase_stk[5];
		phase_ram = '{256, 1, 511, 0, 200};
		phase_stk = '{1024, 0, 2047, 5, 1024};

		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		cfg_we    = 1'b0;
		cfg_addr  = CFG_SMALL_RAM;
		cfg_wdata = '0;
		cycles = 0; errors = 0; mismatches = 0; n_sent = 0; n_checked = 0;
		no_gaps = 0; hold_off = 0;
		foreach (n_status[i]) n_status[i] = 0;
		foreach (shadow_b[i]) begin shadow_b[i] = 0; shadow_w[i] = 0; end
		foreach (shadow_mem[i]) shadow_mem[i] = 0;
		zf = 0; sf = 0;
		ram_cfg = 256; stk_cfg = 1024;
		set_layout();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Early rows run with zero flags, so error codes can be written out.
		add_row(mk(OP_MOVE, 0, 0, AK_IMM, 0, 'hFF, BK_REG, 1, 0), 1, ST_OK, 'hFF);
		add_row(mk(OP_MOVE, 1, 0, AK_IMM, 0, 'hFFFF, BK_REG, 31, 0), 1, ST_OK, 'hFFFF);
		add_row(mk(OP_DIV, 0, 0, AK_IMM, 0, 0, BK_REG, 1, 0), 1, ST_DIVZ);
		add_row(mk(OP_STB, 0, 0, AK_IMM, 0, 'h5A, BK_ABS, 0, 'h10), 1, ST_REGION);
		add_row(mk(OP_POP, 0, 0, AK_REG, 0, 0, BK_REG, 2, 0), 1, ST_UNF);
		add_row(mk(OP_QUIT, 0, 0, AK_REG, 0, 0, BK_REG, 0, 0), 1, ST_HALT);
		add_row(mk(OP_ADD, 0, 0, 3'd7, 0, 0, BK_REG, 0, 0), 1, ST_BAD);
		add_row(mk(5'd31, 1, 1, AK_REG, 0, 0, BK_REG, 0, 0), 1, ST_BAD);
		add_row(mk(OP_STW, 1, 0, AK_IMM, 0, 'h1234, BK_ABS, 0, 'hFFFF), 1, ST_OOB);
		add_row(mk(OP_LDB, 0, 0, AK_REG, 3, 0, BK_REG, 4, 0), 1, ST_BAD);
		// checked by the model from here on
		add_row(mk(OP_ADD, 0, 0, AK_REG, 1, 0, BK_REG, 1, 0));
		add_row(mk(OP_MOVE, 1, 0, AK_IMM, 0, 'h8000, BK_REG, 2, 0));
		add_row(mk(OP_DIV, 1, 1, AK_IMM, 0, 'hFFFF, BK_REG, 2, 0));
		add_row(mk(OP_MUL, 1, 0, AK_REG, 31, 0, BK_REG, 31, 0));
		add_row(mk(OP_SHL, 0, 0, AK_IMM, 0, 8, BK_REG, 1, 0));
		add_row(mk(OP_SHR, 1, 0, AK_IMM, 0, 15, BK_REG, 31, 0));
		add_row(mk(OP_STB, 0, 0, AK_IMM, 0, 'hC3, BK_ABS, 0, 'hFFFF));
		add_row(mk(OP_INC, 1, 0, AK_REG, 0, 0, BK_VIA16, 31, 0));
		add_row(mk(OP_NEG, 1, 0, AK_REG, 0, 0, BK_REG, 2, 0));
		add_row(mk(OP_PUSH, 1, 0, AK_REG, 2, 0, BK_REG, 0, 0));
		add_row(mk(OP_POP, 0, 0, AK_REG, 0, 0, BK_REG, 5, 0));
		add_row(mk(OP_LDB, 0, 0, AK_IMM, 0, 'hFFFF, BK_REG, 6, 0));
		add_row(mk(OP_CMP, 0, 0, AK_IMM, 0, 'h7F, BK_REG, 6, 0));
		add_row(mk(OP_JL, 0, 0, AK_REG, 0, 0, BK_REG, 0, 0));
		add_row(mk(OP_JG, 0, 0, AK_REG, 0, 0, BK_REG, 0, 0));

		foreach (table_rows[i]) begin
			send_req(table_rows[i].q);
			if (table_rows[i].typed) begin
				got = pending_rsp[pending_rsp.size() - 1];
				if (got !== table_rows[i].e) begin
					errors++;
					$display("row %0d: typed %p, model %p", i, table_rows[i].e, got);
				end
			end
		end

		// Random part, one block per memory layout.
		for (int p = 0; p < 5; p++) begin
			if (p > 0) set_map(phase_ram[p], phase_stk[p]);
			for (int i = 0; i < RAND_ITEMS; i++) begin
				if (i == 20) no_gaps = (p % 2 == 0);
				if (i == 50) no_gaps = 0;
				if (p == 2 && i == 60) hold_off = 1;
				send_req(rand_req());
			end
		end

		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("%0d requests over five memory layouts, %0d responses checked", n_sent,
		         n_checked);
		$display("status mix ok/divz/oob/ovf/unf/region/bad/halt: %0d %0d %0d %0d %0d %0d %0d %0d",
		         n_status[0], n_status[1], n_status[2], n_status[3], n_status[4],
		         n_status[5], n_status[6], n_status[7]);
		if (errors == 0)
			$display("tb_toy_cpu_execute_unit: clean");
		else
			$display("tb_toy_cpu_execute_unit: errors");
		$finish;
	end

endmodule
